// ===== rtl/mqsb_pkg.sv =====
// Package: sizes, codes and shared types of the multi-queue shared buffer.
`default_nettype none
package mqsb_pkg;

  localparam int SLOTS  = 16;
  localparam int QUEUES = 4;

  localparam int SIDX_W = $clog2(SLOTS);
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int DATA_W = 32;

  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(SLOTS);

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [SIDX_W-1:0] rd_addr;
    logic              link_we;
    logic [SIDX_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic              val_we;
    logic [SIDX_W-1:0] val_waddr;
    logic [DATA_W-1:0] val_wdata;
  } mem_cmd_t;

  function automatic logic [QIDX_W-1:0] qsel(input logic [1:0] x);
    logic [2:0] t;
    t = {1'b0, x};
    if (QUEUES == 1) begin
      t = 3'd0;
    end else if (int'(x) >= QUEUES) begin
      t = t - 3'(QUEUES);
    end
    return QIDX_W'(t);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mqsb_if.sv =====
// Interfaces: request and response channels of the multi-queue shared buffer.
`default_nettype none
interface mqsb_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [1:0]         queue_index;
  logic signed [31:0] item_value;

  modport source (output valid, mode, queue_index, item_value, input ready);
  modport sink (input valid, mode, queue_index, item_value, output ready);
endinterface

interface mqsb_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/multi_queue_shared_buffer.sv =====
// Top level: several FIFO queues sharing one linked slot store with a free list.
//
// Usage:
//   req carries one operation per beat: mode 0 enqueues item_value onto queue
//   queue_index, mode 1 dequeues the oldest value of that queue.
//   rsp returns exactly one beat per request: read_value and status
//   (ok, store full on enqueue, queue empty on dequeue with read_value -1).
// Sequencing:
//   A request is accepted only while the sequencer is idle; the accepting edge
//   reads the link memory and value memory. Once the response register is free,
//   the execute state writes back and loads the response register, which
//   raises rsp.valid. The sequencer returns to idle only then, so the next
//   request waits until the current operation has written back.
// Reset:
//   rst (synchronous) empties all queues and puts every slot on the free list.
//   Link entries never written read as the initial chain through a fill mark,
//   so no clearing pass is needed; the block takes a request right after reset.
// Stall:
//   A finished response waits in the output register; the next request is
//   still accepted, and its write-back holds until the response register frees.
`default_nettype none
module multi_queue_shared_buffer
  import mqsb_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  mqsb_req_if.sink    req,
  mqsb_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [SLOT_W-1:0] head [QUEUES];
  logic [SIDX_W-1:0] tail [QUEUES];
  logic [SLOT_W-1:0] free_head;
  logic [SLOT_W-1:0] fill;

  logic              op_mode;
  logic [QIDX_W-1:0] op_q;
  logic [DATA_W-1:0] op_val;
  logic [SIDX_W-1:0] op_addr;
  logic              op_fresh;

  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;

  mem_cmd_t          cmd;
  logic [SLOT_W-1:0] link_rd;
  logic [DATA_W-1:0] value_rd;

  logic              accept;
  logic              done;
  logic [QIDX_W-1:0] q_in;
  logic [SLOT_W-1:0] rd_code;
  logic [SLOT_W-1:0] link_cur;
  logic [SLOT_W-1:0] op_head;
  logic              enq_ok;
  logic              deq_ok;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign done      = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign q_in    = qsel(req.queue_index);
  assign rd_code = (req.mode == MODE_ENQ) ? free_head : head[q_in];

  assign link_cur = op_fresh ? (SLOT_W'(op_addr) + SLOT_W'(1)) : link_rd;
  assign op_head  = head[op_q];
  assign enq_ok   = (op_mode == MODE_ENQ) && (free_head < NULL_SLOT);
  assign deq_ok   = (op_mode == MODE_DEQ) && (op_head < NULL_SLOT);

  always_comb begin
    cmd            = '0;
    cmd.rd_en      = accept;
    cmd.rd_addr    = rd_code[SIDX_W-1:0];
    cmd.val_waddr  = free_head[SIDX_W-1:0];
    cmd.val_wdata  = op_val;
    cmd.val_we     = done && enq_ok;
    cmd.link_waddr = tail[op_q];
    cmd.link_wdata = free_head;
    if (done && enq_ok && (op_head < NULL_SLOT)) begin
      cmd.link_we = 1'b1;
    end
    if (done && deq_ok) begin
      cmd.link_we    = 1'b1;
      cmd.link_waddr = op_head[SIDX_W-1:0];
    end
  end

  mqsb_mem u_mem (
    .clk      (clk),
    .cmd      (cmd),
    .link_rd  (link_rd),
    .value_rd (value_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= req.mode;
      op_q     <= q_in;
      op_val   <= req.item_value;
      op_addr  <= rd_code[SIDX_W-1:0];
      op_fresh <= (rd_code >= fill);
    end
    if (done) begin
      if (op_mode == MODE_ENQ) begin
        out_value  <= '0;
        out_status <= enq_ok ? ST_OK : ST_FULL;
      end else if (deq_ok) begin
        out_value  <= value_rd;
        out_status <= ST_OK;
      end else begin
        out_value  <= '1;
        out_status <= ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NULL_SLOT;
        tail[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (done && enq_ok) begin
        free_head <= link_cur;
        if (op_head >= NULL_SLOT) begin
          head[op_q] <= free_head;
        end
        tail[op_q] <= free_head[SIDX_W-1:0];
        if (free_head >= fill) begin
          fill <= fill + SLOT_W'(1);
        end
      end
      if (done && deq_ok) begin
        head[op_q] <= (tail[op_q] == op_head[SIDX_W-1:0]) ? NULL_SLOT : link_cur;
        free_head  <= op_head;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_free_code: assert property (@(posedge clk) disable iff (rst)
    free_head <= NULL_SLOT)
    else $error("free head holds an invalid slot code");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= NULL_SLOT)
    else $error("fill mark beyond slot count");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_value == '1))
    else $error("underflow response without all-ones value");

endmodule
`default_nettype wire

// ===== rtl/mqsb_mem.sv =====
// Slot store: link memory and value memory, with registered reads.
`default_nettype none
module mqsb_mem
  import mqsb_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_cmd_t          cmd,
  output logic [SLOT_W-1:0]      link_rd,
  output logic [DATA_W-1:0]      value_rd
);

  logic [SLOT_W-1:0] link_mem  [SLOTS];
  logic [DATA_W-1:0] value_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      link_mem[cmd.link_waddr] <= cmd.link_wdata;
    end
    if (cmd.val_we) begin
      value_mem[cmd.val_waddr] <= cmd.val_wdata;
    end
    if (cmd.rd_en) begin
      link_rd  <= link_mem[cmd.rd_addr];
      value_rd <= value_mem[cmd.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_multi_queue_shared_buffer.sv =====
// Testbench: shared-slot queue buffer checked beat by beat against a local queue predictor.
`default_nettype none
module tb_multi_queue_shared_buffer
  import mqsb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 1325;
  localparam int STALL_LIMIT = 400;
  localparam int TAIL_CYCLES = 10;
  localparam int PEND_DEPTH  = 8;

  typedef struct packed {
    logic        typed;
    logic        mode;
    logic [1:0]  qi;
    logic [31:0] value;
    logic [31:0] exp_value;
    status_t     exp_status;
  } op_row_t;

  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  mqsb_req_if req_ch ();
  mqsb_rsp_if rsp_ch ();

  multi_queue_shared_buffer u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  logic [SLOT_W-1:0] q_head    [QUEUES];
  logic [SLOT_W-1:0] q_tail    [QUEUES];
  logic [SLOT_W-1:0] next_slot [SLOTS];
  logic [31:0]       slot_data [SLOTS];
  logic [SLOT_W-1:0] free_ptr;

  queue_result_t pending_results [PEND_DEPTH];
  int            pend_wr = 0;
  int            pend_rd = 0;
  int            fail_count = 0;
  int            idle_cycles = 0;
  int            send_calm = 0;

  logic        row_typed;
  logic [31:0] row_exp_value;
  status_t     row_exp_status;

  op_row_t dir_rows [DIR_ROWS];

  function automatic void clear_queues();
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = NULL_SLOT;
      q_tail[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      next_slot[i] = SLOT_W'(i + 1);
      slot_data[i] = '0;
    end
    next_slot[SLOTS-1] = NULL_SLOT;
    free_ptr = '0;
  endfunction

  function automatic void apply_queue_op(input logic m, input logic [1:0] qi,
                                         input logic [31:0] v,
                                         output logic [31:0] rv, output status_t st);
    int q;
    logic [SLOT_W-1:0] s;
    q  = int'(qi) % QUEUES;
    rv = '0;
    st = ST_OK;
    if (m == MODE_ENQ) begin
      s = free_ptr;
      if (s >= SLOTS) begin
        st = ST_FULL;
        return;
      end
      free_ptr = next_slot[s];
      if (q_head[q] >= SLOTS) begin
        q_head[q] = s;
      end else if (q_tail[q] < SLOTS) begin
        next_slot[q_tail[q]] = s;
      end
      next_slot[s] = NULL_SLOT;
      q_tail[q]    = s;
      slot_data[s] = v;
    end else begin
      s = q_head[q];
      if (s >= SLOTS) begin
        rv = '1;
        st = ST_EMPTY;
        return;
      end
      q_head[q]    = next_slot[s];
      next_slot[s] = free_ptr;
      free_ptr     = s;
      rv           = slot_data[s];
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_op(input logic m, input logic [1:0] qi, input logic [31:0] v,
                         input logic typed, input logic [31:0] ev, input status_t es);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      send_calm = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = idle_len();
    end
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.mode        = m;
    req_ch.queue_index = qi;
    req_ch.item_value  = v;
    row_typed          = typed;
    row_exp_value      = ev;
    row_exp_status     = es;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  // hold ready low for random stretches, with calm runs of steady ready
  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        hold--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          calm = $urandom_range(20, 80);
        end else begin
          hold = idle_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0]   rv;
    status_t       st;
    queue_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        apply_queue_op(req_ch.mode, req_ch.queue_index, req_ch.item_value, rv, st);
        if (row_typed) begin
          rv = row_exp_value;
          st = row_exp_status;
        end
        want.read_value = rv;
        want.status     = st;
        if (pend_wr - pend_rd >= PEND_DEPTH) begin
          $error("more than %0d operations pending", PEND_DEPTH);
          fail_count++;
        end
        pending_results[pend_wr % PEND_DEPTH] = want;
        pend_wr++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pend_wr == pend_rd) begin
          $error("response beat with no operation pending: read_value %0d status %0d",
                 $signed(rsp_ch.read_value), rsp_ch.status);
          fail_count++;
        end else begin
          want = pending_results[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(want.read_value), $signed(rsp_ch.read_value));
            fail_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_multi_queue_shared_buffer failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          enq_pct;
    logic        m;
    logic [31:0] v;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_ENQ;
    req_ch.queue_index = '0;
    req_ch.item_value  = '0;
    row_typed          = 1'b0;
    row_exp_value      = '0;
    row_exp_status     = ST_OK;
    clear_queues();

    dir_rows = '{
      '{1'b1, MODE_DEQ, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF, ST_EMPTY},
      '{1'b1, MODE_ENQ, 2'd0, 32'h7FFF_FFFF, 32'h0000_0000, ST_OK},
      '{1'b1, MODE_ENQ, 2'd1, 32'h8000_0000, 32'h0000_0000, ST_OK},
      '{1'b1, MODE_DEQ, 2'd0, 32'h0000_0000, 32'h7FFF_FFFF, ST_OK},
      '{1'b1, MODE_DEQ, 2'd1, 32'hFFFF_FFFF, 32'h8000_0000, ST_OK},
      '{1'b1, MODE_DEQ, 2'd1, 32'h0000_0000, 32'hFFFF_FFFF, ST_EMPTY},
      '{1'b0, MODE_ENQ, 2'd2, 32'h0000_0000, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'hFFFF_FFFF, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd2, 32'h5555_5555, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'hAAAA_AAAA, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd0, 32'h0000_0001, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd2, 32'h8000_0000, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'h7FFF_FFFF, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd0, 32'h1234_5678, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd2, 32'hFEDC_BA98, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'h0F0F_0F0F, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd0, 32'hF0F0_F0F0, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd2, 32'h0000_FFFF, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'hFFFF_0000, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd0, 32'h3333_CCCC, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd2, 32'hCCCC_3333, 32'h0, ST_OK},
      '{1'b0, MODE_ENQ, 2'd3, 32'h0000_0002, 32'h0, ST_OK},
      '{1'b1, MODE_ENQ, 2'd1, 32'h6666_6666, 32'h0000_0000, ST_FULL},
      '{1'b0, MODE_DEQ, 2'd2, 32'h0000_0000, 32'h0, ST_OK},
      '{1'b0, MODE_DEQ, 2'd3, 32'h0000_0000, 32'h0, ST_OK}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(dir_rows[i].mode, dir_rows[i].qi, dir_rows[i].value,
              dir_rows[i].typed, dir_rows[i].exp_value, dir_rows[i].exp_status);
    end

    // hold off until the buffer has answered every beat
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait_drained();

    enq_pct = 50;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 85;
          default: enq_pct = $urandom_range(35, 65);
        endcase
      end
      if ($urandom_range(0, 199) == 0) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait_drained();
      end
      m = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      case ($urandom_range(0, 19))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        3: v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      send_op(m, 2'($urandom_range(0, 3)), v, 1'b0, 32'h0, ST_OK);
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pend_wr != pend_rd) begin
      $error("%0d responses never arrived", pend_wr - pend_rd);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_multi_queue_shared_buffer passed");
    end else begin
      $display("tb_multi_queue_shared_buffer failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
